FILE: src/pplj_pkg.sv
// shared types, constants and register codes of the periodic pair energy unit
package pplj_pkg;

    localparam int POS_W  = 24;
    localparam int RAD_W  = 20;
    localparam int K_W    = 16;
    localparam int D2_W   = 50;
    localparam int Q_W    = 22;
    localparam int E_W    = 48;
    localparam int S_W    = 28;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register indexes of the configuration port
    localparam logic REG_BOX_LENGTH    = 1'b0;
    localparam logic REG_NONADDITIVITY = 1'b1;

    localparam logic [POS_W-1:0] BOX_LENGTH_RESET    = 24'd1048576;
    localparam logic [K_W-1:0]   NONADDITIVITY_RESET = 16'd13107;

    // sigma window on the radius sum, q.16
    localparam logic signed [S_W-1:0] WIN_LOW  = 28'sd193331;
    localparam logic signed [S_W-1:0] WIN_HIGH = 28'sd195953;

    // sigma^2 << 16 for sigma 1.0 and 1.414
    localparam logic [48:0] NUM_ONE  = 49'd281474976710656;
    localparam logic [48:0] NUM_WIDE = 49'd562781108568064;

    localparam logic [Q_W-1:0] U_LIMIT    = 22'd2621440;
    localparam logic [15:0]    FOUR_EPS   = 16'd62527;
    localparam logic [E_W-1:0] ENERGY_MAX = 48'h7FFF_FFFF_FFFF;

    typedef struct packed {
        logic [POS_W-1:0] first_x;
        logic [POS_W-1:0] first_y;
        logic [POS_W-1:0] first_z;
        logic [RAD_W-1:0] first_radius;
        logic [POS_W-1:0] second_x;
        logic [POS_W-1:0] second_y;
        logic [POS_W-1:0] second_z;
        logic [RAD_W-1:0] second_radius;
    } in_item_t;

    typedef struct packed {
        logic [E_W-1:0] energy;
        logic           beyond_cutoff;
        logic           saturated;
    } out_item_t;

    // one classified pair waiting for the energy evaluation
    typedef struct packed {
        logic [D2_W-1:0] d2;
        logic            wide_sigma;
        logic            beyond;
    } pair_entry_t;

endpackage

FILE: src/periodic_pair_lj_energy_unit.sv
// top level of the periodic lennard-jones pair energy unit
//
// one beat in carries two spheres (q8.16 centers, q4.16 radii); one beat out
// carries their 12-6 pair energy (q31.16, saturating) with a cutoff flag and
// a saturation flag. a new pair is taken every cycle unless the front end is
// stalled by a full queue; a pair's result passes 5 front stages, the queue,
// an entry stage, 22 divider stages, 4 multiply stages and the output
// register; the divider forms sigma^2/d^2 one quotient bit per stage.
// the front end folds each axis into the periodic box, forms d^2 and the
// non-additive radius sum and decides the cutoff; a 4-entry queue lets it
// keep taking beats while the back end is held by out_ready. configuration
// (box_length at index 0, nonadditivity at index 1) is written through
// cfg_we / cfg_index / cfg_data and must only change while the unit is idle
module periodic_pair_lj_energy_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [pplj_pkg::POS_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  pplj_pkg::in_item_t         in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output pplj_pkg::out_item_t        out_data
);
    import pplj_pkg::*;

    // configuration registers
    logic [POS_W-1:0] box_length_reg;
    logic [K_W-1:0]   nonadditivity_reg;

    // front end to queue
    logic        push_valid, push_ready;
    pair_entry_t push_data;

    // queue to back end
    logic        pop_valid, pop_ready;
    pair_entry_t pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_length_reg    <= BOX_LENGTH_RESET;
            nonadditivity_reg <= NONADDITIVITY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BOX_LENGTH:    box_length_reg    <= cfg_data;
                REG_NONADDITIVITY: nonadditivity_reg <= cfg_data[K_W-1:0];
                default:           ;
            endcase
        end
    end

    // fold, distance, radius sum and cutoff classification
    pplj_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .box_length    (box_length_reg),
        .nonadditivity (nonadditivity_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    // decouples the two halves so each can stall on its own
    pplj_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // divider, power chain and energy with saturation
    pplj_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: src/pplj_front.sv
// front end: minimum image fold, squared distance, radius sum and cutoff test
module pplj_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  pplj_pkg::in_item_t         in_data,
    input  logic [pplj_pkg::POS_W-1:0] box_length,
    input  logic [pplj_pkg::K_W-1:0]   nonadditivity,
    output logic                       push_valid,
    input  logic                       push_ready,
    output pplj_pkg::pair_entry_t      push_data
);
    import pplj_pkg::*;

    function automatic logic [POS_W-1:0] fold_mag(
        input logic [POS_W-1:0] a,
        input logic [POS_W-1:0] b,
        input logic [POS_W-1:0] len
    );
        logic signed [POS_W+1:0] d;
        logic signed [POS_W+1:0] l;
        logic signed [POS_W+1:0] r;
        d = $signed({2'b00, a}) - $signed({2'b00, b});
        l = $signed({2'b00, len});
        if ((d <<< 1) > l)
        begin
            r = d - l;
        end
        else if ((d <<< 1) < -l)
        begin
            r = d + l;
        end
        else
        begin
            r = d;
        end
        return (r < 0) ? POS_W'(-r) : POS_W'(r);
    endfunction

    logic en;

    logic             a_valid_reg;
    logic [POS_W-1:0] a_mx_reg, a_my_reg, a_mz_reg;
    logic [RAD_W-1:0] a_rdiff_reg;
    logic [RAD_W:0]   a_rsum_reg;

    logic                 b_valid_reg;
    logic [2*POS_W-1:0]   b_sqx_reg, b_sqy_reg, b_sqz_reg;
    logic [K_W+RAD_W-1:0] b_kd_reg;
    logic [RAD_W:0]       b_rsum_reg;

    logic                c_valid_reg;
    logic [D2_W-1:0]     c_d2_reg;
    logic signed [59:0]  c_prod_reg;

    logic              d_valid_reg;
    logic [D2_W-1:0]   d_d2_reg;
    logic [POS_W-1:0]  d_c_reg;
    logic              d_wide_reg, d_neg_reg, d_zero_reg;

    logic              e_valid_reg;
    logic [D2_W-1:0]   e_d2_reg;
    logic [2*POS_W-1:0] e_cc_reg;
    logic              e_wide_reg, e_neg_reg, e_zero_reg;

    logic [RAD_W-1:0]   rdiff;
    logic signed [38:0] factor;
    logic signed [59:0] rsum_s, factor_s, prod;
    logic signed [59:0] prod_bias;
    logic signed [S_W-1:0] s;
    logic [POS_W-1:0]   c5;

    assign en       = !e_valid_reg || push_ready;
    assign in_ready = en;

    assign rdiff = (in_data.first_radius > in_data.second_radius)
                 ? in_data.first_radius - in_data.second_radius
                 : in_data.second_radius - in_data.first_radius;

    assign factor   = 39'sd4294967296 - $signed({2'b00, b_kd_reg, 1'b0});
    assign rsum_s   = $signed(60'(b_rsum_reg));
    assign factor_s = 60'(factor);
    assign prod     = rsum_s * factor_s;

    // truncate toward zero on the division by 2^32
    assign prod_bias = c_prod_reg + ((c_prod_reg < 0) ? 60'sd4294967295 : 60'sd0);
    assign s         = S_W'(prod_bias >>> 32);
    assign c5        = POS_W'({2'b00, s[21:0]} * 24'd5);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mx_reg    <= fold_mag(in_data.first_x, in_data.second_x, box_length);
            a_my_reg    <= fold_mag(in_data.first_y, in_data.second_y, box_length);
            a_mz_reg    <= fold_mag(in_data.first_z, in_data.second_z, box_length);
            a_rdiff_reg <= rdiff;
            a_rsum_reg  <= {1'b0, in_data.first_radius} + {1'b0, in_data.second_radius};

            b_sqx_reg  <= (2*POS_W)'(a_mx_reg) * (2*POS_W)'(a_mx_reg);
            b_sqy_reg  <= (2*POS_W)'(a_my_reg) * (2*POS_W)'(a_my_reg);
            b_sqz_reg  <= (2*POS_W)'(a_mz_reg) * (2*POS_W)'(a_mz_reg);
            b_kd_reg   <= (K_W+RAD_W)'(nonadditivity) * (K_W+RAD_W)'(a_rdiff_reg);
            b_rsum_reg <= a_rsum_reg;

            c_d2_reg   <= D2_W'(b_sqx_reg) + D2_W'(b_sqy_reg) + D2_W'(b_sqz_reg);
            c_prod_reg <= prod;

            d_d2_reg   <= c_d2_reg;
            d_c_reg    <= c5;
            d_wide_reg <= !((s >= WIN_LOW) && (s < WIN_HIGH));
            d_neg_reg  <= (s < 0);
            d_zero_reg <= (s == 0);

            e_d2_reg   <= d_d2_reg;
            e_cc_reg   <= (2*POS_W)'(d_c_reg) * (2*POS_W)'(d_c_reg);
            e_wide_reg <= d_wide_reg;
            e_neg_reg  <= d_neg_reg;
            e_zero_reg <= d_zero_reg;
        end
    end

    assign push_valid           = e_valid_reg;
    assign push_data.d2         = e_d2_reg;
    assign push_data.wide_sigma = e_wide_reg;
    assign push_data.beyond     = e_neg_reg ? 1'b1
                                : e_zero_reg ? (e_d2_reg != '0)
                                : ({e_d2_reg, 4'b0000} > (D2_W+4)'(e_cc_reg));

endmodule

FILE: src/pplj_queue.sv
// short fifo between the front end and the energy back end
module pplj_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  pplj_pkg::pair_entry_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output pplj_pkg::pair_entry_t pop_data
);
    import pplj_pkg::*;

    pair_entry_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/pplj_back.sv
// back end: pipelined divider for u, power chain and energy saturation
module pplj_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  pplj_pkg::pair_entry_t pop_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pplj_pkg::out_item_t   out_data
);
    import pplj_pkg::*;

    logic en;

    // divider stages, index 0 is the entry stage
    logic            dv_valid_reg  [Q_W+1];
    logic [D2_W-1:0] dv_rem_reg    [Q_W+1];
    logic [Q_W-1:0]  dv_quo_reg    [Q_W+1];
    logic [D2_W-1:0] dv_d2_reg     [Q_W+1];
    logic            dv_wide_reg   [Q_W+1];
    logic            dv_beyond_reg [Q_W+1];
    logic            dv_ovf_reg    [Q_W+1];

    logic [26:0] num_hi;

    logic              m1_valid_reg, m1_sat_reg, m1_beyond_reg;
    logic [Q_W-1:0]    m1_u_reg;
    logic [2*Q_W-1:0]  m1_uu_reg;

    logic              m2_valid_reg, m2_sat_reg, m2_beyond_reg;
    logic [48:0]       m2_u2u_reg;

    logic              m3_valid_reg, m3_sat_reg, m3_beyond_reg;
    logic [31:0]       m3_u3_reg;
    logic [63:0]       m3_u6f_reg;

    logic              m4_valid_reg, m4_sat_reg, m4_beyond_reg, m4_neg_reg;
    logic [63:0]       m4_prod_reg;

    logic              o_valid_reg;
    out_item_t         o_data_reg;

    logic [Q_W-1:0]  u_fin;
    logic            sat_fin;
    logic [26:0]     u2;
    logic [31:0]     u3;
    logic [E_W-1:0]  u6, mag, p;
    logic            neg;
    out_item_t       o_next;

    assign en        = !o_valid_reg || out_ready;
    assign pop_ready = en;

    assign num_hi = pop_data.wide_sigma ? NUM_WIDE[48:Q_W] : NUM_ONE[48:Q_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rem_reg[0]    <= D2_W'(num_hi);
            dv_quo_reg[0]    <= '0;
            dv_d2_reg[0]     <= pop_data.d2;
            dv_wide_reg[0]   <= pop_data.wide_sigma;
            dv_beyond_reg[0] <= pop_data.beyond;
            dv_ovf_reg[0]    <= (D2_W'(num_hi) >= pop_data.d2);
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar i = 0; i < Q_W; i++)
    begin : g_div
        logic            num_bit;
        logic [D2_W:0]   trial;
        logic            ge;

        assign num_bit = dv_wide_reg[i] ? NUM_WIDE[Q_W-1-i] : NUM_ONE[Q_W-1-i];
        assign trial   = {dv_rem_reg[i], num_bit};
        assign ge      = (trial >= {1'b0, dv_d2_reg[i]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[i+1] <= dv_valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[i+1]    <= ge ? D2_W'(trial - {1'b0, dv_d2_reg[i]}) : D2_W'(trial);
                dv_quo_reg[i+1]    <= {dv_quo_reg[i][Q_W-2:0], ge};
                dv_d2_reg[i+1]     <= dv_d2_reg[i];
                dv_wide_reg[i+1]   <= dv_wide_reg[i];
                dv_beyond_reg[i+1] <= dv_beyond_reg[i];
                dv_ovf_reg[i+1]    <= dv_ovf_reg[i];
            end
        end
    end

    assign u_fin   = dv_quo_reg[Q_W];
    assign sat_fin = dv_ovf_reg[Q_W] || (u_fin >= U_LIMIT);

    assign u2  = m1_uu_reg[42:16];
    assign u3  = m2_u2u_reg[47:16];
    assign u6  = m3_u6f_reg[63:16];
    assign neg = (u6 < E_W'(m3_u3_reg));
    assign mag = neg ? E_W'(m3_u3_reg) - u6 : u6 - E_W'(m3_u3_reg);
    assign p   = m4_prod_reg[63:16];

    always_comb
    begin
        o_next.energy        = '0;
        o_next.beyond_cutoff = m4_beyond_reg;
        o_next.saturated     = 1'b0;
        if (!m4_beyond_reg)
        begin
            if (m4_sat_reg)
            begin
                o_next.energy    = ENERGY_MAX;
                o_next.saturated = 1'b1;
            end
            else if (m4_neg_reg)
            begin
                o_next.energy = -p;
            end
            else if (p[E_W-1])
            begin
                o_next.energy    = ENERGY_MAX;
                o_next.saturated = 1'b1;
            end
            else
            begin
                o_next.energy = p;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
            m4_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= dv_valid_reg[Q_W];
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
            m4_valid_reg <= m3_valid_reg;
            o_valid_reg  <= m4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_u_reg      <= u_fin;
            m1_uu_reg     <= (2*Q_W)'(u_fin) * (2*Q_W)'(u_fin);
            m1_sat_reg    <= sat_fin;
            m1_beyond_reg <= dv_beyond_reg[Q_W];

            m2_u2u_reg    <= 49'(u2) * 49'(m1_u_reg);
            m2_sat_reg    <= m1_sat_reg;
            m2_beyond_reg <= m1_beyond_reg;

            m3_u3_reg     <= u3;
            m3_u6f_reg    <= 64'(u3) * 64'(u3);
            m3_sat_reg    <= m2_sat_reg;
            m3_beyond_reg <= m2_beyond_reg;

            m4_prod_reg   <= 64'(mag) * 64'(FOUR_EPS);
            m4_neg_reg    <= neg;
            m4_sat_reg    <= m3_sat_reg;
            m4_beyond_reg <= m3_beyond_reg;

            o_data_reg    <= o_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule
